@@ rtl/asc_pkg.sv @@
// shared widths, codes and controller/datapath interface types of the adc sample converter
`default_nettype none

package asc_pkg;

  // default depth of the breakpoint store
  localparam int unsigned TableDepthDef = 16;

  // field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned ValW     = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned MultW    = 16;
  localparam int unsigned DivW     = 16;
  localparam int unsigned OffW     = 32;
  localparam int unsigned EntW     = 5;

  // stream and config port widths
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // divider sizing: numerator magnitude stays below 2^48
  localparam int unsigned MagW      = 48;
  localparam int unsigned DivSteps  = MagW;
  localparam int unsigned StepCntW  = 6;

  // conversion modes
  localparam logic [ModeW-1:0] ModePass   = 2'd0;
  localparam logic [ModeW-1:0] ModeLinear = 2'd1;
  localparam logic [ModeW-1:0] ModeAbs    = 2'd2;
  localparam logic [ModeW-1:0] ModeTable  = 2'd3;

  // result status codes
  localparam logic [StatusW-1:0] StatOk      = 2'd0;
  localparam logic [StatusW-1:0] StatDivZero = 2'd1;
  localparam logic [StatusW-1:0] StatSat     = 2'd2;

  // request kinds
  localparam logic ActConvert = 1'b0;
  localparam logic ActWrite   = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgMode    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMult    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDiv     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOffset  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgEntries = 3'd4;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic div_init;
    logic div_step;
    logic tbl_rd;
    logic tbl_cmp;
    logic emit;
  } asc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic             is_write;
    logic [ModeW-1:0] mode;
    logic             div_zero;
    logic             div_last;
    logic             tbl_hit;
    logic             out_free;
  } asc_stat_t;

endpackage

`default_nettype wire

@@ rtl/asc_ctrl.sv @@
// sequencing state machine of the adc sample converter
`default_nettype none

module asc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  asc_pkg::asc_stat_t  stat_i,
  output asc_pkg::asc_cmd_t   cmd_o
);
  import asc_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StMul     = 3'd1;
  localparam logic [2:0] StSum     = 3'd2;
  localparam logic [2:0] StDivInit = 3'd3;
  localparam logic [2:0] StDiv     = 3'd4;
  localparam logic [2:0] StTblRd   = 3'd5;
  localparam logic [2:0] StTblCmp  = 3'd6;
  localparam logic [2:0] StDone    = 3'd7;

  logic [2:0] state_q, state_d;

  // one request at a time, taken only when idle
  assign s_tready_o = (state_q == StIdle);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.is_write == ActConvert) begin
            case (stat_i.mode)
              ModePass:  state_d = StDone;
              ModeTable: state_d = StTblRd;
              default:   state_d = stat_i.div_zero ? StDone : StMul;
            endcase
          end
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StDivInit;
      end
      StDivInit: begin
        cmd_o.div_init = 1'b1;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = StDone;
        end
      end
      StTblRd: begin
        cmd_o.tbl_rd = 1'b1;
        state_d      = StTblCmp;
      end
      StTblCmp: begin
        cmd_o.tbl_cmp = 1'b1;
        state_d       = stat_i.tbl_hit ? StDone : StTblRd;
      end
      StDone: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // a table write finishes in its accept cycle
  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && stat_i.is_write == ActWrite) |=> state_q == StIdle)
    else $error("write request left idle state");

  // after handing off a result the controller is free again
  a_emit_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == StIdle)
    else $error("controller not idle after result hand-off");

  // datapath gets at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");

endmodule

`default_nettype wire

@@ rtl/asc_datapath.sv @@
// registers, multipliers, restoring divider, breakpoint store and output stage
`default_nettype none

module asc_datapath #(
  parameter int unsigned TABLE_DEPTH = asc_pkg::TableDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [asc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [asc_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [asc_pkg::InDataW-1:0]     s_tdata_i,
  input  logic                            s_tuser_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [asc_pkg::OutDataW-1:0]    m_tdata_o,
  output logic [asc_pkg::StatusW-1:0]     m_tuser_o,
  input  asc_pkg::asc_cmd_t               cmd_i,
  output asc_pkg::asc_stat_t              stat_o
);
  import asc_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned EntryW = ThrW + ValW;
  localparam logic [ValW-1:0] IntMax = 32'h7FFF_FFFF;
  localparam logic [ValW-1:0] IntMin = 32'h8000_0000;
  localparam logic [MagW-1:0] MagMaxPos = 48'h0000_7FFF_FFFF;
  localparam logic [MagW-1:0] MagMaxNeg = 48'h0000_8000_0000;

  // request fields
  logic [SampleW-1:0]      in_sample;
  logic [IndexW-1:0]       in_index;
  logic [ThrW-1:0]         in_thr;
  logic [ValW-1:0]         in_out;

  assign in_sample = s_tdata_i[15:0];
  assign in_index  = s_tdata_i[19:16];
  assign in_thr    = s_tdata_i[35:20];
  assign in_out    = s_tdata_i[67:36];

  // configuration registers
  logic [ModeW-1:0]        mode_q;
  logic signed [MultW-1:0] mult_q;
  logic signed [DivW-1:0]  div_q;
  logic signed [OffW-1:0]  off_q;
  logic [EntW-1:0]         ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePass;
      mult_q <= 16'sd1;
      div_q  <= 16'sd1;
      off_q  <= '0;
      ent_q  <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMode:    mode_q <= cfg_data_i[ModeW-1:0];
        CfgMult:    mult_q <= cfg_data_i[MultW-1:0];
        CfgDiv:     div_q  <= cfg_data_i[DivW-1:0];
        CfgOffset:  off_q  <= cfg_data_i[OffW-1:0];
        CfgEntries: ent_q  <= cfg_data_i[EntW-1:0];
        default: ;
      endcase
    end
  end

  // sample plus offset, formed while the request is taken
  logic signed [ValW:0]    t_sum;
  logic [IdxW-1:0]         idx_init;

  assign t_sum = $signed({off_q[OffW-1], off_q}) + $signed({17'b0, in_sample});

  // last entry in use, clamped to the store depth
  always_comb begin
    if (ent_q == '0) begin
      idx_init = '0;
    end else if (32'(ent_q) > TABLE_DEPTH) begin
      idx_init = IdxW'(TABLE_DEPTH - 1);
    end else begin
      idx_init = IdxW'(ent_q - EntW'(1));
    end
  end

  logic [SampleW-1:0]      sample_q;
  logic signed [ValW:0]    mula_q;
  logic                    tneg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= in_sample;
      mula_q   <= (mode_q == ModeLinear) ? $signed({17'b0, in_sample}) : t_sum;
      tneg_q   <= t_sum[ValW];
    end
  end

  // multiply stage
  logic signed [48:0]      p1_q;
  logic signed [47:0]      p2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p1_q <= 49'(mula_q) * 49'(mult_q);
      p2_q <= 48'(off_q) * 48'(div_q);
    end
  end

  // numerator: linear sum or magnitude-scaled product
  logic signed [48:0]      num_q;
  logic signed [48:0]      lin_sum;
  logic signed [48:0]      abs_prod;

  assign lin_sum  = p1_q + 49'(p2_q);
  assign abs_prod = tneg_q ? -p1_q : p1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      num_q <= (mode_q == ModeLinear) ? lin_sum : abs_prod;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [MagW-1:0]         mag_q;
  logic [DivW-1:0]         rem_q;
  logic [DivW-1:0]         dmag_q;
  logic                    qneg_q;
  logic [StepCntW-1:0]     cnt_q;
  logic signed [48:0]      num_neg;
  logic [DivW-1:0]         div_neg;
  logic [DivW:0]           r2;
  logic [DivW:0]           rdiff;
  logic                    r_ge;

  assign num_neg = -num_q;
  assign div_neg = -div_q;
  assign r2      = {rem_q, mag_q[MagW-1]};
  assign rdiff   = r2 - {1'b0, dmag_q};
  assign r_ge    = (r2 >= {1'b0, dmag_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      mag_q  <= num_q[48] ? num_neg[MagW-1:0] : num_q[MagW-1:0];
      dmag_q <= div_q[DivW-1] ? div_neg : div_q;
      qneg_q <= num_q[48] ^ div_q[DivW-1];
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      mag_q <= {mag_q[MagW-2:0], r_ge};
      rem_q <= r_ge ? rdiff[DivW-1:0] : r2[DivW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + StepCntW'(1);
    end
  end

  // breakpoint store: threshold and output per entry
  logic [EntryW-1:0]       tbl_mem [TABLE_DEPTH];
  logic [ThrW-1:0]         rd_thr_q;
  logic [ValW-1:0]         rd_out_q;
  logic [IdxW-1:0]         idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && s_tuser_i == ActWrite && 32'(in_index) < TABLE_DEPTH) begin
      tbl_mem[IdxW'(in_index)] <= {in_thr, in_out};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_rd) begin
      {rd_thr_q, rd_out_q} <= tbl_mem[idx_q];
    end
  end

  // downward scan of the store
  logic                    tbl_hit;
  logic signed [ValW:0]    tsum_q;

  assign tbl_hit = (idx_q == '0) || (sample_q < rd_thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= idx_init;
    end else if (cmd_i.tbl_cmp && !tbl_hit) begin
      idx_q <= idx_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_cmp && tbl_hit) begin
      tsum_q <= $signed({rd_out_q[ValW-1], rd_out_q}) + $signed({off_q[OffW-1], off_q});
    end
  end

  // final value with saturation
  logic [ValW-1:0]         res_val;
  logic [StatusW-1:0]      res_st;

  always_comb begin
    res_val = '0;
    res_st  = StatOk;
    case (mode_q)
      ModePass: begin
        res_val = {16'b0, sample_q};
      end
      ModeLinear, ModeAbs: begin
        if (div_q == '0) begin
          res_st = StatDivZero;
        end else if (qneg_q) begin
          if (mag_q > MagMaxNeg) begin
            res_val = IntMin;
            res_st  = StatSat;
          end else begin
            res_val = -mag_q[ValW-1:0];
          end
        end else if (mag_q > MagMaxPos) begin
          res_val = IntMax;
          res_st  = StatSat;
        end else begin
          res_val = mag_q[ValW-1:0];
        end
      end
      default: begin
        if (tsum_q[ValW] != tsum_q[ValW-1]) begin
          res_val = tsum_q[ValW] ? IntMin : IntMax;
          res_st  = StatSat;
        end else begin
          res_val = tsum_q[ValW-1:0];
        end
      end
    endcase
  end

  // output register
  logic                    out_valid_q;
  logic [ValW-1:0]         out_val_q;
  logic [StatusW-1:0]      out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_val_q <= res_val;
      out_st_q  <= res_st;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_val_q;
  assign m_tuser_o  = out_st_q;

  // status to controller
  assign stat_o.is_write = s_tuser_i;
  assign stat_o.mode     = mode_q;
  assign stat_o.div_zero = (div_q == '0);
  assign stat_o.div_last = (cnt_q == StepCntW'(DivSteps - 1));
  assign stat_o.tbl_hit  = tbl_hit;
  assign stat_o.out_free = !out_valid_q || m_tready_i;

  // a result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || m_tready_i))
    else $error("result register overwritten");

  // divider never runs past its last quotient bit
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> cnt_q < StepCntW'(DivSteps))
    else $error("divider step count overrun");

  // a finished divide leaves the step counter at its end
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && stat_o.div_last) |=> cnt_q == StepCntW'(DivSteps))
    else $error("divider ended at wrong step");

endmodule

`default_nettype wire

@@ rtl/adc_sample_converter_unit.sv @@
// top level of the adc sample converter
`default_nettype none

// Converts one unsigned 16-bit sample per request into a saturated signed
// 32-bit value by the mode in register 0: pass-through, linear scaling,
// absolute value then scaling, or a downward breakpoint table scan. A request
// with tuser high writes one table entry and gives no result; entries must be
// written before a scan reads them. Requests are handled one at a time and a
// new one is taken while the previous result still waits at the output.
// A table write finishes in its accept cycle; pass-through and a zero divisor
// skip the arithmetic; linear and absolute pass a multiply and a sum stage,
// then the 48-step restoring divider (one quotient bit per cycle); table mode
// scans entries downward, each through a registered read of the store.
// The configuration registers may only be written while no request is open.

module adc_sample_converter_unit #(
  parameter int unsigned TABLE_DEPTH = asc_pkg::TableDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [asc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [asc_pkg::CfgDataW-1:0] cfg_data_i,
  // request stream
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  // sample [15:0], entry_index [19:16], entry_threshold [35:20],
  // entry_output [67:36], zeros [71:68]
  input  logic [asc_pkg::InDataW-1:0]  s_tdata_i,
  // action [0]
  input  logic                         s_tuser_i,
  // result stream
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  // converted [31:0]
  output logic [asc_pkg::OutDataW-1:0] m_tdata_o,
  // status [1:0]
  output logic [asc_pkg::StatusW-1:0]  m_tuser_o
);
  import asc_pkg::*;

  asc_cmd_t  cmd;
  asc_stat_t stat;

  // sequencing
  asc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic, store and output stage
  asc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// self-checking testbench for adc_sample_converter_unit, directed rows then random phases
`default_nettype none

module tb;
  import asc_pkg::*;

  // cycles with no request, result or register write before the run is called hung
  localparam int unsigned QuietLimit = 3000;
  // cycles granted after the last result so table writes can finish
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned RandomPhases = 12;
  localparam int unsigned PhaseRequests = 150;
  localparam longint ValMax = 64'sd2147483647;
  localparam longint ValMin = -64'sd2147483648;

  typedef struct packed {
    logic [ValW-1:0]    value;
    logic [StatusW-1:0] status;
  } reading_t;

  typedef enum logic [1:0] {RowReg, RowConv, RowWrite} row_kind_e;

  // a: register index / sample / entry index, b: register value / threshold, c: entry output
  typedef struct packed {
    row_kind_e          kind;
    logic [31:0]        a;
    logic [31:0]        b;
    logic [31:0]        c;
    logic               known;
    logic [ValW-1:0]    want;
    logic [StatusW-1:0] want_st;
  } row_t;

  localparam int unsigned ScriptLen = 41;

  row_t script [ScriptLen] = '{
    '{RowConv,  32'd0,      32'd0,            32'd0,         1'b1, 32'd0,         StatOk},
    '{RowConv,  32'd65535,  32'd0,            32'd0,         1'b1, 32'd65535,     StatOk},
    '{RowReg,   CfgMode,    ModeLinear,       32'd0,         1'b0, 32'd0,         StatOk},
    '{RowReg,   CfgOffset,  32'h7FFF_FFFF,    32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd65535,  32'd0,            32'd0,         1'b1, 32'h7FFF_FFFF, StatSat},
    '{RowReg,   CfgMult,    32'hFFFF_8000,    32'd0,         1'b0, 32'd0,         StatOk},
    '{RowReg,   CfgOffset,  32'h8000_0000,    32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd65535,  32'd0,            32'd0,         1'b1, 32'h8000_0000, StatSat},
    '{RowConv,  32'd0,      32'd0,            32'd0,         1'b1, 32'h8000_0000, StatOk},
    '{RowReg,   CfgDiv,     32'hFFFF_8000,    32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd12345,  32'd0,            32'd0,         1'b0, 32'd0,         StatOk},
    '{RowReg,   CfgMult,    32'h0000_7FFF,    32'd0,         1'b0, 32'd0,         StatOk},
    '{RowReg,   CfgOffset,  32'h1234_5678,    32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd54321,  32'd0,            32'd0,         1'b0, 32'd0,         StatOk},
    '{RowReg,   CfgDiv,     32'd0,            32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd777,    32'd0,            32'd0,         1'b1, 32'd0,         StatDivZero},
    '{RowReg,   CfgMode,    ModeAbs,          32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd100,    32'd0,            32'd0,         1'b1, 32'd0,         StatDivZero},
    '{RowReg,   CfgDiv,     32'h0000_7FFF,    32'd0,         1'b0, 32'd0,         StatOk},
    '{RowReg,   CfgOffset,  32'h8000_0000,    32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd0,      32'd0,            32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd65535,  32'd0,            32'd0,         1'b0, 32'd0,         StatOk},
    '{RowReg,   CfgOffset,  32'hFFFF_FF00,    32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd256,    32'd0,            32'd0,         1'b1, 32'd0,         StatOk},
    '{RowConv,  32'd0,      32'd0,            32'd0,         1'b1, 32'd256,       StatOk},
    '{RowReg,   CfgMode,    ModeTable,        32'd0,         1'b0, 32'd0,         StatOk},
    '{RowReg,   CfgOffset,  32'h7FFF_FFFF,    32'd0,         1'b0, 32'd0,         StatOk},
    '{RowWrite, 32'd0,      32'd0,            32'd1,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd9,      32'd0,            32'd0,         1'b1, 32'h7FFF_FFFF, StatSat},
    '{RowReg,   CfgOffset,  32'd0,            32'd0,         1'b0, 32'd0,         StatOk},
    '{RowWrite, 32'd0,      32'h0000_FFFF,    32'h8000_0000, 1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd0,      32'd0,            32'd0,         1'b1, 32'h8000_0000, StatOk},
    '{RowReg,   CfgEntries, 32'd0,            32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd65535,  32'd0,            32'd0,         1'b1, 32'h8000_0000, StatOk},
    '{RowReg,   CfgEntries, 32'd31,           32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd0,      32'd0,            32'd0,         1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd65535,  32'd0,            32'd0,         1'b0, 32'd0,         StatOk},
    '{RowReg,   CfgEntries, 32'd16,           32'd0,         1'b0, 32'd0,         StatOk},
    '{RowWrite, 32'd15,     32'h0000_FFFF,    32'h7FFF_FFFF, 1'b0, 32'd0,         StatOk},
    '{RowConv,  32'd65534,  32'd0,            32'd0,         1'b1, 32'h7FFF_FFFF, StatOk},
    '{RowConv,  32'd65535,  32'd0,            32'd0,         1'b0, 32'd0,         StatOk}
  };

  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;
  logic                s_tvalid   = 1'b0;
  logic                s_tready_o;
  // sample, entry_index, entry_threshold, entry_output, zero pad
  logic [InDataW-1:0]  s_tdata    = '0;
  // action
  logic                s_tuser    = 1'b0;
  logic                m_tvalid_o;
  logic                m_tready   = 1'b1;
  // converted
  logic [OutDataW-1:0] m_tdata_o;
  // status
  logic [StatusW-1:0]  m_tuser_o;

  // bench copy of the registers and the breakpoint store
  logic [ModeW-1:0]        mode_q   = ModePass;
  logic signed [MultW-1:0] mult_q   = 16'sd1;
  logic signed [DivW-1:0]  div_q    = 16'sd1;
  logic signed [OffW-1:0]  offset_q = '0;
  logic [EntW-1:0]         ent_q    = 5'd1;
  logic [ThrW-1:0]         thr_tab [16];
  logic signed [ValW-1:0]  val_tab [16];

  reading_t awaited_readings [$];
  bit       idle_on = 1'b1;
  bit       busy    = 1'b0;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  adc_sample_converter_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // expected reading of one sample under the current settings
  function automatic reading_t convert_sample(logic [SampleW-1:0] smp);
    longint   s;
    longint   acc;
    int       n;
    int       k;
    reading_t r;
    s = smp;
    r.status = StatOk;
    acc = 0;
    case (mode_q)
      ModePass: acc = s;
      ModeLinear: begin
        if (div_q == 0) r.status = StatDivZero;
        else acc = (s * mult_q + longint'(offset_q) * div_q) / div_q;
      end
      ModeAbs: begin
        if (div_q == 0) r.status = StatDivZero;
        else begin
          acc = s + longint'(offset_q);
          if (acc < 0) acc = -acc;
          acc = (acc * mult_q) / div_q;
        end
      end
      default: begin
        n = ent_q;
        if (n == 0) n = 1;
        if (n > 16) n = 16;
        k = n - 1;
        while (k > 0 && smp >= thr_tab[k]) k--;
        acc = longint'(val_tab[k]) + longint'(offset_q);
      end
    endcase
    if (acc > ValMax) begin
      acc = ValMax;
      r.status = StatSat;
    end else if (acc < ValMin) begin
      acc = ValMin;
      r.status = StatSat;
    end
    r.value = acc[ValW-1:0];
    return r;
  endfunction

  // one register write, then cfg_we low again before returning so back-to-back writes stay apart
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CfgMode:    mode_q = data[ModeW-1:0];
      CfgMult:    mult_q = data[MultW-1:0];
      CfgDiv:     div_q = data[DivW-1:0];
      CfgOffset:  offset_q = data[OffW-1:0];
      CfgEntries: ent_q = data[EntW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold off until every result is back and the block has had time to finish writes
  task automatic wait_for_idle();
    if (busy) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
      while (awaited_readings.size() != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
      busy = 1'b0;
    end
  endtask

  // present one request, wait for its handshake, then update the bench state
  task automatic send_request(input logic act, input logic [SampleW-1:0] smp,
                              input logic [IndexW-1:0] idx, input logic [ThrW-1:0] thr,
                              input logic [ValW-1:0] val, input bit known,
                              input reading_t typed);
    while (idle_on && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0, val, thr, idx, smp};
    do @(posedge clk_i); while (!s_tready_o);
    busy = 1'b1;
    if (act == ActWrite) begin
      thr_tab[idx] = thr;
      val_tab[idx] = val;
    end else begin
      awaited_readings.push_back(known ? typed : convert_sample(smp));
    end
  endtask

  function automatic logic [31:0] pick_short();
    logic [15:0] v;
    case ($urandom_range(7))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'h0000;
      3: v = 16'h0001;
      4: v = 16'hFFFF;
      5: v = 16'($signed($urandom_range(32)) - 16);
      default: v = 16'($urandom);
    endcase
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] pick_long();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'($signed($urandom_range(140000)) - 70000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return thr_tab[$urandom_range(15)] + 16'($urandom_range(2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    reading_t exp_r;
    if (rst_ni && m_tvalid_o && m_tready) begin
      if (awaited_readings.size() == 0) begin
        $error("result with nothing expected: converted %0d status %0d",
               $signed(m_tdata_o), m_tuser_o);
        mismatches++;
      end else begin
        exp_r = awaited_readings.pop_front();
        if (m_tdata_o !== exp_r.value) begin
          $error("converted: expected %0d, got %0d", $signed(exp_r.value), $signed(m_tdata_o));
          mismatches++;
        end
        if (m_tuser_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_tuser_o);
          mismatches++;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    m_tready <= idle_on ? ($urandom_range(99) >= 9) : 1'b1;
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready_o) || (m_tvalid_o && m_tready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("[adc_sample_converter_unit] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    row_t     row;
    reading_t typed;
    int       i;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole store so no scan reads an unwritten entry
    for (i = 0; i < 16; i++) begin
      send_request(ActWrite, 16'($urandom), 4'(i), 16'(i * 4000), 32'(i * 1000 - 7000),
                   1'b0, '0);
    end

    // directed rows
    for (i = 0; i < ScriptLen; i++) begin
      row = script[i];
      typed.value  = row.want;
      typed.status = row.want_st;
      case (row.kind)
        RowReg: begin
          wait_for_idle();
          write_reg(row.a[CfgIdxW-1:0], row.b);
        end
        RowConv: send_request(ActConvert, row.a[15:0], 4'($urandom), 16'($urandom), $urandom,
                              row.known, typed);
        default: send_request(ActWrite, 16'($urandom), row.a[3:0], row.b[15:0], row.c,
                              1'b0, '0);
      endcase
    end

    // random phases, each under fresh settings; one phase runs without any idling
    for (int ph = 0; ph < RandomPhases; ph++) begin
      wait_for_idle();
      idle_on = (ph != 6);
      write_reg(CfgMode, 32'(ph % 4));
      write_reg(CfgMult, pick_short());
      write_reg(CfgDiv, pick_short());
      write_reg(CfgOffset, pick_long());
      write_reg(CfgEntries, ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 16));
      for (int n = 0; n < PhaseRequests; n++) begin
        if ($urandom_range(99) < 15)
          send_request(ActWrite, 16'($urandom), 4'($urandom),
                       ($urandom_range(7) == 0) ? {16{$urandom_range(1) == 1}} : 16'($urandom),
                       pick_long(), 1'b0, '0);
        else
          send_request(ActConvert, pick_sample(), 4'($urandom), 16'($urandom), $urandom,
                       1'b0, '0);
      end
    end

    wait_for_idle();
    if (mismatches == 0) begin
      $display("[adc_sample_converter_unit] OK");
    end else begin
      $display("[adc_sample_converter_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
